@@ rtl/sfisa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfisa_pkg
// Shared types and constants for the slab free index stack allocator: sizes,
// request and result beats, status and configuration codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sfisa_pkg;

  localparam int unsigned SLAB_BYTES   = 16384;
  localparam int unsigned MAX_OBJECTS  = 1024;
  localparam int unsigned ADDRESS_BITS = 48;

  localparam int unsigned ADDR_W  = ADDRESS_BITS;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned IDX_W   = $clog2(MAX_OBJECTS);
  localparam int unsigned AREA_W  = COUNT_W + SIZE_W;
  localparam int unsigned BIT_W   = $clog2(IDX_W);
  localparam int unsigned CFG_W   = 2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_NONE_IN_USE = 2'd2,
    ST_OUT_OF_AREA = 2'd3
  } status_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_SLAB_BASE    = 2'd0,
    CFG_OBJECT_SIZE  = 2'd1,
    CFG_OBJECT_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MUL,
    S_BASE,
    S_AREA,
    S_AMUL,
    S_AADD,
    S_FOFF,
    S_FCMP,
    S_DIV,
    S_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [ADDR_W-1:0] object_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    status_e            status;
    logic [COUNT_W-1:0] objects_in_use;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/sfisa_ram.sv @@
// ----------------------------------------------------------------------------
// sfisa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfisa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfisa_alu.sv @@
// ----------------------------------------------------------------------------
// sfisa_alu
// Shared address-wide adder / subtractor with borrow out; used for the area
// start, the object address, the offset, the range check and every divide step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfisa_alu (
  input  wire sfisa_pkg::alu_op_e                op_i,
  input  wire logic [sfisa_pkg::ADDR_W-1:0]      a_i,
  input  wire logic [sfisa_pkg::ADDR_W-1:0]      b_i,
  output logic      [sfisa_pkg::ADDR_W-1:0]      res_o,
  output logic                                   borrow_o
);

  import sfisa_pkg::*;

  logic [ADDR_W-1:0] b_eff;
  logic [ADDR_W:0]   sum;

  always_comb begin
    b_eff    = (op_i == ALU_SUB) ? ~b_i : b_i;
    sum      = {1'b0, a_i} + {1'b0, b_eff} + (ADDR_W + 1)'(op_i == ALU_SUB);
    res_o    = sum[ADDR_W-1:0];
    // carry out clear on a subtract means a < b
    borrow_o = (op_i == ALU_SUB) && !sum[ADDR_W];
  end

endmodule

`default_nettype wire

@@ rtl/sfisa_mul.sv @@
// ----------------------------------------------------------------------------
// sfisa_mul
// Registered count-by-size multiplier, shared between the area size and the
// offset of an allocated object.
// ----------------------------------------------------------------------------
`default_nettype none

module sfisa_mul (
  input  wire logic                          clk_i,
  input  wire logic [sfisa_pkg::COUNT_W-1:0] a_i,
  input  wire logic [sfisa_pkg::SIZE_W-1:0]  b_i,
  output logic      [sfisa_pkg::AREA_W-1:0]  p_o
);

  import sfisa_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= AREA_W'(a_i) * AREA_W'(b_i);
  end

endmodule

`default_nettype wire

@@ rtl/slab_free_index_stack_allocator_core.sv @@
// ----------------------------------------------------------------------------
// slab_free_index_stack_allocator_core
// Slab allocator for one slab of equal objects: a RAM stack of free indices,
// an in-use count, and a sequencer around a shared adder and multiplier.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction  handshake
//  request   start, busy, req_i                          in         start && !busy
//  result    done_o, result_o                            out        done_o strobe
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,      in         valid && ready
//            cfg_data_i
//
//  before the result strobe a free runs the restoring divide (one quotient bit a
//  cycle on the shared adder); a free outside the area and a request refused up
//  front (no free object, nothing in use) skip it. after reset a clearing pass
//  writes entry i = i over the stack RAM, one entry a cycle, with busy high;
//  config beats are taken throughout. results cannot be stalled: each is on
//  result_o for the single done_o cycle.
`default_nettype none

module slab_free_index_stack_allocator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sfisa_pkg::req_t             req_i,
  output logic                             done_o,
  output sfisa_pkg::res_t                  result_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sfisa_pkg::CFG_W-1:0] cfg_index_i,
  input  wire logic [sfisa_pkg::ADDR_W-1:0] cfg_data_i
);

  import sfisa_pkg::*;

  state_e              state_q, state_d;
  opcode_e             opcode_q, opcode_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   base_q;
  logic [SIZE_W-1:0]   size_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  in_use_q, in_use_d;
  logic [ADDR_W-1:0]   acc_q, acc_d;
  logic [AREA_W-1:0]   area_q, area_d;
  logic [AREA_W-1:0]   rem_q, rem_d;
  logic [IDX_W-1:0]    quo_q, quo_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  res_t                res_q, res_d;

  logic [COUNT_W-1:0]  eff_n;
  logic [COUNT_W-1:0]  rd_pos;
  logic [COUNT_W-1:0]  wr_pos;

  alu_op_e             alu_op;
  logic [ADDR_W-1:0]   alu_a, alu_b, alu_res;
  logic                alu_borrow;

  logic [COUNT_W-1:0]  mul_a;
  logic [AREA_W-1:0]   mul_p;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  sfisa_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  sfisa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (size_q),
    .p_o   (mul_p)
  );

  sfisa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_OBJECTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_n  = (count_q > COUNT_W'(MAX_OBJECTS)) ? COUNT_W'(MAX_OBJECTS) : count_q;
  assign rd_pos = eff_n - in_use_q - COUNT_W'(1);
  assign wr_pos = eff_n - in_use_q;

  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign result_o    = res_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      in_use_q <= '0;
      clr_q    <= '0;
      base_q   <= '0;
      size_q   <= SIZE_RESET;
      count_q  <= COUNT_RESET;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      clr_q    <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SLAB_BASE:    base_q  <= cfg_data_i;
          CFG_OBJECT_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_OBJECT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q <= opcode_d;
    addr_q   <= addr_d;
    acc_q    <= acc_d;
    area_q   <= area_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    bit_q    <= bit_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    opcode_d  = opcode_q;
    addr_d    = addr_q;
    in_use_d  = in_use_q;
    acc_d     = acc_q;
    area_d    = area_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    bit_d     = bit_q;
    clr_d     = clr_q;
    res_d     = res_q;
    alu_op    = ALU_ADD;
    alu_a     = acc_q;
    alu_b     = ADDR_W'(area_q);
    mul_a     = eff_n;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = clr_q;
    ram_re    = 1'b0;
    ram_raddr = rd_pos[IDX_W-1:0];

    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_OBJECTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          opcode_d = req_i.opcode;
          addr_d   = req_i.object_address;
          if (req_i.opcode == OP_ALLOC) begin
            if (in_use_q >= eff_n) begin
              res_d   = '{address: '0, status: ST_NO_FREE, objects_in_use: in_use_q};
              state_d = S_DONE;
            end else begin
              // pop: fetch the top index now, used after the area start is known
              ram_re  = 1'b1;
              state_d = S_MUL;
            end
          end else begin
            if (in_use_q == '0) begin
              res_d   = '{address: '0, status: ST_NONE_IN_USE, objects_in_use: in_use_q};
              state_d = S_DONE;
            end else begin
              state_d = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        state_d = S_BASE;
      end
      S_BASE: begin
        area_d  = mul_p;
        alu_op  = ALU_ADD;
        alu_a   = base_q;
        alu_b   = ADDR_W'(SLAB_BYTES);
        acc_d   = alu_res;
        state_d = S_AREA;
      end
      S_AREA: begin
        alu_op  = ALU_SUB;
        alu_a   = acc_q;
        alu_b   = ADDR_W'(area_q);
        acc_d   = alu_res;
        state_d = (opcode_q == OP_ALLOC) ? S_AMUL : S_FOFF;
      end
      S_AMUL: begin
        mul_a   = COUNT_W'(ram_rdata);
        state_d = S_AADD;
      end
      S_AADD: begin
        alu_op   = ALU_ADD;
        alu_a    = acc_q;
        alu_b    = ADDR_W'(mul_p);
        in_use_d = in_use_q + COUNT_W'(1);
        res_d    = '{address: alu_res, status: ST_OK, objects_in_use: in_use_q + COUNT_W'(1)};
        state_d  = S_DONE;
      end
      S_FOFF: begin
        alu_op  = ALU_SUB;
        alu_a   = addr_q;
        alu_b   = acc_q;
        acc_d   = alu_res;
        state_d = S_FCMP;
      end
      S_FCMP: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = ADDR_W'(area_q);
        if (!alu_borrow) begin
          res_d   = '{address: '0, status: ST_OUT_OF_AREA, objects_in_use: in_use_q};
          state_d = S_DONE;
        end else begin
          rem_d   = acc_q[AREA_W-1:0];
          quo_d   = '0;
          bit_d   = BIT_W'(IDX_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle, msb first
        alu_op = ALU_SUB;
        alu_a  = ADDR_W'(rem_q);
        alu_b  = ADDR_W'(size_q) << bit_q;
        if (!alu_borrow) begin
          rem_d = alu_res[AREA_W-1:0];
        end
        quo_d = {quo_q[IDX_W-2:0], !alu_borrow};
        if (bit_q == '0) begin
          state_d = S_PUSH;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      S_PUSH: begin
        // with the count lowered under use there is no slot to push into
        if (in_use_q <= eff_n) begin
          ram_we    = 1'b1;
          ram_waddr = wr_pos[IDX_W-1:0];
          ram_wdata = quo_q;
        end
        in_use_d = in_use_q - COUNT_W'(1);
        res_d    = '{address: '0, status: ST_OK, objects_in_use: in_use_q - COUNT_W'(1)};
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sfisa_checker.sv @@
// ----------------------------------------------------------------------------
// sfisa_checker
// Port-level checks on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sfisa_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire sfisa_pkg::res_t              result_o
);

  import sfisa_pkg::*;

  // a request beat always makes the core busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("core not busy after request beat");

  // a result strobe only ever ends a request in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // one result beat per request, never two in a row
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // only a successful allocate carries an address
  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |-> (result_o.address == '0))
    else $error("address not zero on refused request");

  // nothing in use is reported with an in-use count of zero
  a_none_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_NONE_IN_USE) |-> (result_o.objects_in_use == '0))
    else $error("nothing-in-use result with objects still counted");

endmodule

bind slab_free_index_stack_allocator_core sfisa_checker u_sfisa_checker (.*);

`default_nettype wire
